@@ hw/rtl/ecbf_pkg.sv @@
// Package for the edge-clipped box filter: shared types and constants.
// No dependencies; every other file of the block imports it.
`default_nettype none

package ecbf_pkg;

  // Configuration port
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_IDX_LSB = 2;              // byte address = 4 * register index
  localparam int RADIUS_W    = 5;

  localparam logic                REG_RADIUS   = 1'b0;   // register index of radius
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd1;

  // Job queue between front and back
  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);
  localparam logic [JOBQ_CNT_W-1:0] JOBQ_FULL = JOBQ_CNT_W'(JOBQ_DEPTH);

  typedef enum logic {
    FS_STREAM,
    FS_FLUSH
  } fr_state_t;

  // Config control to the front: write strobe plus current radius
  typedef struct packed {
    logic                clear;
    logic [RADIUS_W-1:0] radius;
  } cfg_ctl_t;

  // Front status seen by the top level
  typedef struct packed {
    logic flushing;
    logic push;
  } fr_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/ecbf_jobq.sv @@
// Short job FIFO between the front (window sum) and the back (divider).
// Depends on ecbf_pkg for depth constants.
`default_nettype none

module ecbf_jobq #(
  parameter int W = 29
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         pop_valid
);
  import ecbf_pkg::*;

  logic [W-1:0]            q_mem [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [JOBQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [JOBQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                    do_push, do_pop;

  assign push_ready = (cnt_r != JOBQ_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = q_mem[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ecbf_front.sv @@
// Front end: accepts samples, keeps the sample ring and the running window
// sum, sequences the end-of-row flush and emits (sum, count, last) jobs. Uses ecbf_pkg.
`default_nettype none

module ecbf_front #(
  parameter int MAX_RADIUS  = 31,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  ecbf_pkg::cfg_ctl_t                              cfg,
  input  logic                                            in_valid,
  input  logic [SAMPLE_BITS-1:0]                          in_sample,
  input  logic                                            in_last,
  output logic                                            in_ready,
  input  logic                                            q_ready,
  output logic                                            push,
  output logic [SAMPLE_BITS+$clog2(2*MAX_RADIUS+2)-1:0]   job_sum,
  output logic [$clog2(2*MAX_RADIUS+2)-1:0]               job_cnt,
  output logic                                            job_last,
  output ecbf_pkg::fr_stat_t                              stat
);
  import ecbf_pkg::*;

  localparam int HIST_DEPTH = 2 * MAX_RADIUS + 2;
  localparam int CW         = $clog2(HIST_DEPTH);
  localparam int SUM_W      = SAMPLE_BITS + CW;
  localparam logic [CW:0]   DEPTH_C = (CW + 1)'(HIST_DEPTH);
  localparam logic [CW-1:0] SAT_C   = CW'(2 * MAX_RADIUS + 1);

  function automatic logic [CW-1:0] mod_sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] t;
    t = {1'b0, a} - {1'b0, b};
    if (t[CW]) begin
      t = t + DEPTH_C;
    end
    return t[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] mod_inc(input logic [CW-1:0] a);
    logic [CW:0] t;
    t = {1'b0, a} + 1'b1;
    if (t == DEPTH_C) begin
      t = '0;
    end
    return t[CW-1:0];
  endfunction

  fr_state_t        state_r, state_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CW-1:0]    rcv_r, rcv_nxt;        // samples seen this row, saturating
  logic [CW-1:0]    wp_r, wp_nxt;
  logic [CW-1:0]    rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]    q_r, q_nxt;            // flush: row position being emitted
  logic [CW-1:0]    fcnt_r, fcnt_nxt;      // flush: window count for q_r

  logic [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_q_r, byp_data_r, rd_data;
  logic                   byp_r;
  logic                   hist_we;

  logic [CW-1:0]    r, two_r, two_r1, nm1, q0;
  logic             accept, sub_en, flush_end;
  logic [SUM_W-1:0] sum_acc;

  assign r      = CW'(cfg.radius);
  assign two_r  = r << 1;
  assign two_r1 = two_r + 1'b1;
  assign nm1    = (rcv_r >= r) ? r : rcv_r;   // outputs owed at row end, minus one
  assign q0     = rcv_r - nm1;

  assign in_ready  = (state_r == FS_STREAM) && q_ready;
  assign accept    = in_valid && in_ready;
  assign flush_end = (state_r == FS_FLUSH) && q_ready && (q_r == rcv_r);

  // ring read is write-first: same-cycle write to the read slot is forwarded
  assign rd_data = byp_r ? byp_data_r : rd_q_r;
  assign sub_en  = (rcv_r > two_r);
  assign sum_acc = sum_r - (sub_en ? SUM_W'(rd_data) : '0) + SUM_W'(in_sample);

  assign stat.flushing = (state_r == FS_FLUSH);
  assign stat.push     = push;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_STREAM: if (accept && in_last) state_nxt = FS_FLUSH;
      FS_FLUSH:  if (flush_end) state_nxt = FS_STREAM;
    endcase
    if (cfg.clear) begin
      state_nxt = FS_STREAM;
    end
  end

  always_comb begin
    sum_nxt     = sum_r;
    rcv_nxt     = rcv_r;
    wp_nxt      = wp_r;
    rd_addr_nxt = rd_addr_r;
    q_nxt       = q_r;
    fcnt_nxt    = fcnt_r;
    hist_we     = 1'b0;
    push        = 1'b0;
    job_sum     = sum_r;
    job_cnt     = fcnt_r;
    job_last    = 1'b0;
    unique case (state_r)
      FS_STREAM: begin
        rd_addr_nxt = mod_sub(wp_r, two_r1);
        if (accept) begin
          hist_we = 1'b1;
          sum_nxt = sum_acc;
          if (in_last) begin
            q_nxt       = q0;
            fcnt_nxt    = (q0 >= r) ? nm1 + r + 1'b1 : rcv_r + 1'b1;
            rd_addr_nxt = mod_sub(wp_r, nm1 + r);
          end else begin
            push        = (rcv_r >= r);
            job_sum     = sum_acc;
            job_cnt     = ((rcv_r >= two_r) ? two_r : rcv_r) + 1'b1;
            rcv_nxt     = (rcv_r == SAT_C) ? SAT_C : rcv_r + 1'b1;
            wp_nxt      = mod_inc(wp_r);
            rd_addr_nxt = mod_sub(mod_inc(wp_r), two_r1);
          end
        end
      end
      FS_FLUSH: begin
        if (q_ready) begin
          push     = 1'b1;
          job_last = (q_r == rcv_r);
          if (q_r == rcv_r) begin
            sum_nxt     = '0;
            rcv_nxt     = '0;
            wp_nxt      = '0;
            rd_addr_nxt = mod_sub('0, two_r1);
          end else begin
            q_nxt       = q_r + 1'b1;
            rd_addr_nxt = mod_inc(rd_addr_r);
            if (q_r >= r) begin
              // window start moves past sample q-r
              sum_nxt  = sum_r - SUM_W'(rd_data);
              fcnt_nxt = fcnt_r - 1'b1;
            end
          end
        end
      end
    endcase
    if (cfg.clear) begin
      sum_nxt = '0;
      rcv_nxt = '0;
      wp_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= FS_STREAM;
      sum_r     <= '0;
      rcv_r     <= '0;
      wp_r      <= '0;
      rd_addr_r <= '0;
      byp_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sum_r     <= sum_nxt;
      rcv_r     <= rcv_nxt;
      wp_r      <= wp_nxt;
      rd_addr_r <= rd_addr_nxt;
      byp_r     <= hist_we && (wp_r == rd_addr_nxt);
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    fcnt_r <= fcnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wp_r] <= in_sample;
    end
    rd_q_r     <= hist_mem[rd_addr_nxt];
    byp_data_r <= in_sample;
  end

endmodule

`default_nettype wire

@@ hw/rtl/ecbf_div.sv @@
// Back end: pipelined restoring divider, one quotient bit per stage, that
// turns (sum, count) jobs into rounded means. Uses ecbf_pkg.
`default_nettype none

module ecbf_div #(
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_W       = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  logic [SAMPLE_BITS+CNT_W-1:0] job_sum,
  input  logic [CNT_W-1:0]             job_cnt,
  input  logic                         job_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [SAMPLE_BITS-1:0]       out_mean,
  output logic                         out_last
);
  import ecbf_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int SUM_W = SAMPLE_BITS + CNT_W;

  // stage 0 holds the split dividend; stage k holds k quotient bits
  logic [SB:0]        st_v_r;
  logic [SB:0]        st_l_r;
  logic [SB-1:0]      st_x_r   [0:SB];
  logic [CNT_W-1:0]   st_rem_r [0:SB-1];
  logic [CNT_W-1:0]   st_d_r   [0:SB-1];
  logic [CNT_W:0]     st_t     [1:SB];
  logic [CNT_W:0]     st_diff  [1:SB];
  logic [SUM_W-1:0]   dividend;
  logic               adv;

  assign adv       = !st_v_r[SB] || out_ready;
  assign job_ready = adv;
  assign out_valid = st_v_r[SB];
  assign out_mean  = st_x_r[SB];
  assign out_last  = st_l_r[SB];

  // round to nearest, halves up
  assign dividend = job_sum + SUM_W'(job_cnt >> 1);

  always_comb begin
    for (int k = 1; k <= SB; k++) begin
      st_t[k]    = {st_rem_r[k-1], st_x_r[k-1][SB-1]};
      st_diff[k] = st_t[k] - {1'b0, st_d_r[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= '0;
    end else if (adv) begin
      st_v_r <= {st_v_r[SB-1:0], job_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_rem_r[0] <= dividend[SUM_W-1:SB];
      st_x_r[0]   <= dividend[SB-1:0];
      st_d_r[0]   <= job_cnt;
      st_l_r[0]   <= job_last;
      for (int k = 1; k <= SB; k++) begin
        st_x_r[k] <= {st_x_r[k-1][SB-2:0], !st_diff[k][CNT_W]};
        st_l_r[k] <= st_l_r[k-1];
      end
      for (int k = 1; k < SB; k++) begin
        st_rem_r[k] <= st_diff[k][CNT_W] ? st_t[k][CNT_W-1:0] : st_diff[k][CNT_W-1:0];
        st_d_r[k]   <= st_d_r[k-1];
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/edge_clipped_box_filter_1d.sv @@
// Top level of the edge-clipped 1-D box filter: APB register, front end,
// job queue and divider back end. Depends on ecbf_pkg and the ecbf_* modules.
`default_nettype none

// Streams one row of unsigned samples (in_tlast on the final one) and returns,
// for every row position, the mean of the samples within radius on either side,
// with the window clipped at both row ends and divided by the true count,
// rounded to nearest (halves up). Output for position q follows the input
// transaction for position q+radius; the last sample of a row releases the
// remaining min(received, radius)+1 outputs, the final one flagged by
// out_tlast. Rate: one sample per clock while streaming and the job queue
// has room. At the row end the flush sequencer emits one job per clock from
// the sample ring (one RAM read port) while the queue has room, so in_tready
// is low from the last sample until the flush ends. Results come out one per
// clock while out_tready is high, through a one-bit-per-stage divider
// pipeline; a 4-entry job queue lets input keep flowing while out_tready is
// briefly low. radius (register 0, byte address 0, reset 1; pwdata[4:0]) is
// saturated to MAX_RADIUS; writing it abandons the current row.
// Write it only while idle. The sample ring needs no clearing after reset.

module edge_clipped_box_filter_1d #(
  parameter int MAX_RADIUS  = 31,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream; tdata: [SAMPLE_BITS-1:0] sample, rest zero pad
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                 in_tlast,   // row_last
  // result stream; tdata: [SAMPLE_BITS-1:0] mean, rest zero pad
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     out_tdata,
  output logic                                 out_tlast,  // out_last
  // APB configuration port
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [ecbf_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [ecbf_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [ecbf_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);
  import ecbf_pkg::*;

  localparam int CW    = $clog2(2 * MAX_RADIUS + 2);  // count / ring address width
  localparam int SUM_W = SAMPLE_BITS + CW;
  localparam int JOB_W = SUM_W + CW + 1;
  localparam int TD_W  = ((SAMPLE_BITS + 7) / 8) * 8;

  // ---------------- configuration register ----------------
  logic [RADIUS_W-1:0] radius_r, radius_nxt;
  logic [RADIUS_W-1:0] wr_val;
  logic                cfg_wr, cfg_hit;
  cfg_ctl_t            cfg_ctl;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_hit    = cfg_wr && (cfg_paddr[CFG_IDX_LSB] == REG_RADIUS);
  assign wr_val     = cfg_pwdata[RADIUS_W-1:0];

  // pwdata[4:0] above the supported maximum saturates; upper bits are ignored
  assign radius_nxt = (32'(wr_val) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : wr_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_hit) begin
      radius_r <= radius_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_IDX_LSB] == REG_RADIUS) ? CFG_DATA_W'(radius_r) : '0;

  // a radius write also restarts the row in the front end
  assign cfg_ctl.clear  = cfg_hit;
  assign cfg_ctl.radius = radius_r;

  // ---------------- front end ----------------
  logic             job_push, q_push_ready;
  logic [SUM_W-1:0] job_sum;
  logic [CW-1:0]    job_cnt;
  logic             job_last;
  fr_stat_t         fr_stat;

  ecbf_front #(
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_ctl),
    .in_valid  (in_tvalid),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .q_ready   (q_push_ready),
    .push      (job_push),
    .job_sum   (job_sum),
    .job_cnt   (job_cnt),
    .job_last  (job_last),
    .stat      (fr_stat)
  );

  // ---------------- job queue ----------------
  logic [JOB_W-1:0] q_in, q_out;
  logic             q_pop, q_valid;

  assign q_in = {job_last, job_cnt, job_sum};

  ecbf_jobq #(
    .W (JOB_W)
  ) u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_data  (q_in),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_data   (q_out),
    .pop_valid  (q_valid)
  );

  // ---------------- divider back end ----------------
  logic [SAMPLE_BITS-1:0] mean;
  logic                   div_ready;

  assign q_pop = div_ready;

  ecbf_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_ready (div_ready),
    .job_sum   (q_out[SUM_W-1:0]),
    .job_cnt   (q_out[SUM_W+CW-1:SUM_W]),
    .job_last  (q_out[JOB_W-1]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_mean  (mean),
    .out_last  (out_tlast)
  );

  assign out_tdata = TD_W'(mean);

  // ---------------- assertions ----------------
  // no input transaction while the flush sequencer owns the ring
  a_no_input_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    fr_stat.flushing |-> !in_tready)
    else $error("input accepted during row flush");

  // the front never pushes a job the queue cannot take
  a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fr_stat.push |-> q_push_ready)
    else $error("job pushed into full queue");

  // a radius write abandons any flush in progress
  a_cfg_abandons_row: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> !fr_stat.flushing)
    else $error("flush continued after radius write");

endmodule

`default_nettype wire
